>>> design/sfpc_pkg.sv
package sfpc_pkg;

    localparam int BYTE_W = 8;
    localparam int RAW_W  = 16;
    localparam int CONC_W = 20;

    // Fixed bytes of the frame FF 17 04 00 HI LO 13 88 CK
    localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR1_BYTE  = 8'h17;
    localparam logic [BYTE_W-1:0] HDR2_BYTE  = 8'h04;
    localparam logic [BYTE_W-1:0] HDR3_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] TAIL1_BYTE = 8'h13;
    localparam logic [BYTE_W-1:0] TAIL2_BYTE = 8'h88;

    // concentration = raw*13 + floor(raw*392857 / 10^6)
    // floor(x / 10^6) = floor((x >> 6) / 15625), the latter by a rounded-up
    // reciprocal that is exact for every (x >> 6) below 2^29.
    localparam logic [3:0]  SCALE_INT   = 4'd13;
    localparam logic [18:0] SCALE_FRAC  = 19'd392857;
    localparam int          FRAC_W      = 35;
    localparam int          FRAC_DROP   = 6;
    localparam int          Y_W         = 29;
    localparam logic [29:0] RECIP_MULT  = 30'd562949954;
    localparam int          RECIP_SHIFT = 43;
    localparam int          PROD_W      = 59;
    localparam int          Q_W         = 15;

    typedef struct packed {
        logic             valid;
        logic [RAW_W-1:0] raw;
    } t_frame;

endpackage

>>> design/sensor_frame_parser_checksum_unit.sv
// One byte is taken every cycle; bytes are held back only while three results are queued and the output is stalled.
// A result is registered through r_v1, r_v2 and r_vo of the scaling pipeline after its checksum byte transfer.
// Throughput: one result per 9-byte frame; the scaling pipeline takes one per cycle unless stalled.
// Reset (i_rst_n low, synchronous): parser waits for FF, checksum clears, pipeline empties.
module sensor_frame_parser_checksum_unit import sfpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RAW_W-1:0]  o_raw_value,
    output logic [CONC_W-1:0] o_concentration
);

    t_frame w_frame;
    logic   w_ready;
    logic   w_accept;

    assign w_accept = i_valid && w_ready;
    assign o_stall  = !w_ready;

    sfpc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_frame   (w_frame)
    );

    sfpc_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame         (w_frame),
        .o_ready         (w_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_raw_value     (o_raw_value),
        .o_concentration (o_concentration)
    );

endmodule

>>> design/sfpc_parser.sv
module sfpc_parser import sfpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_frame            o_frame
);

    typedef enum logic [3:0] {
        POS_SOF,
        POS_HDR1,
        POS_HDR2,
        POS_HDR3,
        POS_HIGH,
        POS_LOW,
        POS_TAIL1,
        POS_TAIL2,
        POS_CHK
    } t_pos;

    t_pos              r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_high, n_high;
    logic [BYTE_W-1:0] r_low, n_low;
    logic              w_frame_ok;

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum + i_rx_byte;
        n_high     = r_high;
        n_low      = r_low;
        w_frame_ok = 1'b0;
        case (r_pos)
            POS_HDR1: begin
                // restart the checksum with the first byte after FF
                n_sum = i_rx_byte;
                n_pos = (i_rx_byte == HDR1_BYTE) ? POS_HDR2 : POS_SOF;
            end
            POS_HDR2: n_pos = (i_rx_byte == HDR2_BYTE) ? POS_HDR3 : POS_SOF;
            POS_HDR3: n_pos = (i_rx_byte == HDR3_BYTE) ? POS_HIGH : POS_SOF;
            POS_HIGH: begin
                n_high = i_rx_byte;
                n_pos  = POS_LOW;
            end
            POS_LOW: begin
                n_low = i_rx_byte;
                n_pos = POS_TAIL1;
            end
            POS_TAIL1: n_pos = (i_rx_byte == TAIL1_BYTE) ? POS_TAIL2 : POS_SOF;
            POS_TAIL2: n_pos = (i_rx_byte == TAIL2_BYTE) ? POS_CHK : POS_SOF;
            POS_CHK: begin
                w_frame_ok = (n_sum == '0);
                n_pos      = POS_SOF;
            end
            default: begin
                n_sum = r_sum;
                n_pos = (i_rx_byte == SOF_BYTE) ? POS_HDR1 : POS_SOF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_SOF;
            r_sum  <= '0;
            r_high <= '0;
            r_low  <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

    assign o_frame.valid = i_accept & w_frame_ok;
    assign o_frame.raw   = {r_high, r_low};

endmodule

>>> design/sfpc_scale.sv
module sfpc_scale import sfpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame            i_frame,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RAW_W-1:0]  o_raw_value,
    output logic [CONC_W-1:0] o_concentration
);

    logic              r_v1, r_v2, r_vo;
    logic [RAW_W-1:0]  r_raw1, r_raw2, r_raw_o;
    logic [FRAC_W-1:0] r_x1;
    logic [CONC_W-1:0] r_int1, r_int2, r_conc_o;
    logic [Q_W-1:0]    r_q2;

    logic              w_ready_o, w_ready2, w_ready1;
    logic [Y_W-1:0]    w_y;
    logic [PROD_W-1:0] w_prod;

    // a stage advances when it is empty or the next one advances
    assign w_ready_o = !r_vo || !i_stall;
    assign w_ready2  = !r_v2 || w_ready_o;
    assign w_ready1  = !r_v1 || w_ready2;

    assign w_y    = r_x1[FRAC_DROP +: Y_W];
    assign w_prod = PROD_W'(w_y) * PROD_W'(RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_ready1) r_v1 <= i_frame.valid;
            if (w_ready2) r_v2 <= r_v1;
            if (w_ready_o) r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_frame.valid) begin
            r_raw1 <= i_frame.raw;
            r_x1   <= FRAC_W'(i_frame.raw) * FRAC_W'(SCALE_FRAC);
            r_int1 <= CONC_W'(i_frame.raw) * CONC_W'(SCALE_INT);
        end
        if (w_ready2 && r_v1) begin
            r_raw2 <= r_raw1;
            r_int2 <= r_int1;
            r_q2   <= w_prod[RECIP_SHIFT +: Q_W];
        end
        if (w_ready_o && r_v2) begin
            r_raw_o  <= r_raw2;
            r_conc_o <= r_int2 + CONC_W'(r_q2);
        end
    end

    assign o_ready         = w_ready1;
    assign o_valid         = r_vo;
    assign o_raw_value     = r_raw_o;
    assign o_concentration = r_conc_o;

endmodule

>>> design/sfpc_checker.sv
module sfpc_checker import sfpc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [RAW_W-1:0]  o_raw_value,
    input logic [CONC_W-1:0] o_concentration
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_raw_value) && $stable(o_concentration))
        else $error("result changed while stalled");

    // scaled value lies between 13 and 14 times the raw value
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CONC_W'(o_raw_value) * CONC_W'(13) <= o_concentration) &&
                    (o_concentration <= CONC_W'(o_raw_value) * CONC_W'(14)))
        else $error("concentration out of range for raw value");

    // input is held back only while the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // a fresh result follows an accepted byte transfer
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid, 3) && !$past(o_stall, 3))
        else $error("result without a matching byte transfer");

endmodule

bind sensor_frame_parser_checksum_unit sfpc_checker u_sfpc_checker (.*);
